FILE: design/salc_pkg.sv
// ----------------------------------------------------------------------------
// salc_pkg - shared types and constants for the LRU cache tag block
// Controller states, command/status bundles, configuration layout and
// register map used by the controller, datapath and top level.
// ----------------------------------------------------------------------------
package salc_pkg;

  // Default sizing
  localparam int MAX_WAYS_DEF   = 8;
  localparam int MAX_SETS_DEF   = 1024;
  localparam int ADDR_WIDTH_DEF = 32;

  // Field widths fixed by the register map and the result fields
  localparam int OFFSET_W  = 5;
  localparam int INDEX_W   = 4;
  localparam int WAYS_W    = 4;
  localparam int WAY_OUT_W = 3;
  localparam int CNT_W     = 64;
  localparam int IDX_MAX   = 15;   // widest set index that index_bits can select
  localparam int SHIFT_W   = 6;    // offset_bits + index_bits

  // Register map
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam logic [1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [1:0] REG_INDEX_BITS  = 2'd1;
  localparam logic [1:0] REG_WAYS_IN_USE = 2'd2;

  // Reset values of the configuration registers
  localparam logic [OFFSET_W-1:0] OFFSET_RST = 5'd5;
  localparam logic [INDEX_W-1:0]  INDEX_RST  = 4'd6;
  localparam logic [WAYS_W-1:0]   WAYS_RST   = 4'd4;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset_bits;
    logic [INDEX_W-1:0]  index_bits;
    logic [WAYS_W-1:0]   ways_in_use;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } ctrl_state_t;

  typedef struct packed {
    logic clr_we;    // write reset row at clear pointer
    logic capture;   // latch address split for a new transfer
    logic rd_en;     // read the selected set
    logic commit;    // write back the set, bump counters, load result
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;  // clear pointer is on the last set
  } dp_sts_t;

endpackage

FILE: design/salc_ctrl.sv
// ----------------------------------------------------------------------------
// salc_ctrl - sequencer for the LRU cache tag block
// Runs the post-reset clearing pass, then steps each access through
// capture, set read and write-back, and owns the result valid flag.
// ----------------------------------------------------------------------------
module salc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output salc_pkg::dp_cmd_t cmd,
  input  salc_pkg::dp_sts_t sts
);

  salc_pkg::ctrl_state_t state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  can_commit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= salc_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign can_commit = !out_valid_r || out_ready;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_ready    = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      salc_pkg::ST_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (sts.clr_last) begin
          state_nxt = salc_pkg::ST_IDLE;
        end
      end
      salc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = salc_pkg::ST_LOOKUP;
        end
      end
      salc_pkg::ST_LOOKUP: begin
        cmd.rd_en = 1'b1;
        state_nxt = salc_pkg::ST_UPDATE;
      end
      salc_pkg::ST_UPDATE: begin
        // wait here until the result slot is free; read data stays put
        if (can_commit) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          in_ready      = 1'b1;
          if (in_valid) begin
            cmd.capture = 1'b1;
            state_nxt   = salc_pkg::ST_LOOKUP;
          end else begin
            state_nxt = salc_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = salc_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

FILE: design/salc_dpath.sv
// ----------------------------------------------------------------------------
// salc_dpath - address split, set memory and LRU update
// Splits the address into set and tag, reads one set row, resolves hit or
// LRU victim, writes the row back and keeps the access and miss counters.
// ----------------------------------------------------------------------------
module salc_dpath #(
  parameter int MAX_WAYS   = salc_pkg::MAX_WAYS_DEF,
  parameter int MAX_SETS   = salc_pkg::MAX_SETS_DEF,
  parameter int ADDR_WIDTH = salc_pkg::ADDR_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  salc_pkg::cfg_t                      cfg,
  input  salc_pkg::dp_cmd_t                   cmd,
  output salc_pkg::dp_sts_t                   sts,
  input  logic [ADDR_WIDTH-1:0]               in_address,
  output logic                                out_hit,
  output logic [salc_pkg::WAY_OUT_W-1:0]      out_way,
  output logic [salc_pkg::CNT_W-1:0]          out_access_count,
  output logic [salc_pkg::CNT_W-1:0]          out_miss_count
);

  localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int IDX_W  = salc_pkg::IDX_MAX;
  localparam int SHW    = ADDR_WIDTH + IDX_W;
  // ceil(2^31 / MAX_SETS): exact quotient for any index below 2^15
  localparam logic [31:0] RECIP =
    32'(((64'd1 << 31) + 64'(MAX_SETS) - 64'd1) / 64'(MAX_SETS));

  // Set memory, one row per set
  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_mem  [MAX_SETS];
  logic [MAX_WAYS-1:0]                 vld_mem  [MAX_SETS];
  logic [MAX_WAYS-1:0][WAY_W-1:0]      rank_mem [MAX_SETS];

  logic [SET_W-1:0] clr_cnt_r;

  logic [IDX_W-1:0]      x_r, x_nxt;
  logic [IDX_W-1:0]      q_r, q_nxt;
  logic [ADDR_WIDTH-1:0] tag_r, tag_nxt;
  logic [SET_W-1:0]      set_r, set_nxt;

  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] rd_tags_r;
  logic [MAX_WAYS-1:0]                 rd_vld_r;
  logic [MAX_WAYS-1:0][WAY_W-1:0]      rd_rank_r;

  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] wr_tags;
  logic [MAX_WAYS-1:0]                 wr_vld;
  logic [MAX_WAYS-1:0][WAY_W-1:0]      wr_rank;
  logic [MAX_WAYS-1:0][WAY_W-1:0]      init_rank;

  logic [salc_pkg::CNT_W-1:0] acc_cnt_r, miss_cnt_r;

  logic [4:0]       ways_eff;
  logic             hit;
  logic [WAY_W-1:0] hit_way, victim, sel_way;
  logic [31:0]      sel_way32;

  // ---------------- address split (capture cycle) ----------------
  always_comb begin
    logic [SHW-1:0]              addr_ext;
    logic [SHW-1:0]              sh;
    logic [IDX_W:0]              mask;
    logic [salc_pkg::SHIFT_W-1:0] tshift;
    logic [IDX_W+31:0]           prod;
    addr_ext = SHW'(in_address);
    sh       = addr_ext >> cfg.offset_bits;
    mask     = ((IDX_W+1)'(1) << cfg.index_bits) - (IDX_W+1)'(1);
    x_nxt    = sh[IDX_W-1:0] & mask[IDX_W-1:0];
    tshift   = salc_pkg::SHIFT_W'(cfg.offset_bits) + salc_pkg::SHIFT_W'(cfg.index_bits);
    if (7'(tshift) >= 7'(ADDR_WIDTH)) begin
      tag_nxt = '0;
    end else begin
      tag_nxt = in_address >> tshift;
    end
    prod  = (IDX_W+32)'(x_nxt) * (IDX_W+32)'(RECIP);
    q_nxt = prod[IDX_W+30:31];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r   <= x_nxt;
      q_r   <= q_nxt;
      tag_r <= tag_nxt;
    end
  end

  // set = x mod MAX_SETS
  always_comb begin
    logic [31:0] qm;
    logic [31:0] rem;
    qm      = 32'(q_r) * 32'(MAX_SETS);
    rem     = 32'(x_r) - qm;
    set_nxt = rem[SET_W-1:0];
  end

  // ---------------- clearing pass ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_we) begin
      clr_cnt_r <= clr_cnt_r + SET_W'(1);
    end
  end

  assign sts.clr_last = (clr_cnt_r == SET_W'(MAX_SETS - 1));

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      init_rank[w] = WAY_W'(w);
    end
  end

  // ---------------- memory ports ----------------
  always_ff @(posedge clk) begin
    if (cmd.clr_we) begin
      tag_mem[clr_cnt_r]  <= '0;
      vld_mem[clr_cnt_r]  <= '0;
      rank_mem[clr_cnt_r] <= init_rank;
    end else if (cmd.commit) begin
      tag_mem[set_r]  <= wr_tags;
      vld_mem[set_r]  <= wr_vld;
      rank_mem[set_r] <= wr_rank;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_tags_r <= tag_mem[set_nxt];
      rd_vld_r  <= vld_mem[set_nxt];
      rd_rank_r <= rank_mem[set_nxt];
      set_r     <= set_nxt;
    end
  end

  // ---------------- lookup and LRU update ----------------
  always_comb begin
    if (cfg.ways_in_use == '0) begin
      ways_eff = 5'd1;
    end else if (5'(cfg.ways_in_use) > 5'(MAX_WAYS)) begin
      ways_eff = 5'(MAX_WAYS);
    end else begin
      ways_eff = 5'(cfg.ways_in_use);
    end
  end

  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    // walk down so the lowest matching way wins
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if ((5'(w) < ways_eff) && rd_vld_r[w] && (rd_tags_r[w] == tag_r)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
  end

  always_comb begin
    logic [WAY_W-1:0] best;
    best   = rd_rank_r[0];
    victim = '0;
    for (int w = 1; w < MAX_WAYS; w++) begin
      if ((5'(w) < ways_eff) && (rd_rank_r[w] > best)) begin
        best   = rd_rank_r[w];
        victim = WAY_W'(w);
      end
    end
  end

  assign sel_way = hit ? hit_way : victim;

  always_comb begin
    logic [WAY_W-1:0] r_sel;
    r_sel   = rd_rank_r[sel_way];
    wr_tags = rd_tags_r;
    wr_vld  = rd_vld_r;
    for (int k = 0; k < MAX_WAYS; k++) begin
      if (WAY_W'(k) == sel_way) begin
        wr_rank[k] = '0;
      end else if (rd_rank_r[k] < r_sel) begin
        wr_rank[k] = rd_rank_r[k] + WAY_W'(1);
      end else begin
        wr_rank[k] = rd_rank_r[k];
      end
    end
    if (!hit) begin
      wr_tags[sel_way] = tag_r;
      wr_vld[sel_way]  = 1'b1;
    end
  end

  // ---------------- counters and result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_cnt_r  <= '0;
      miss_cnt_r <= '0;
    end else if (cmd.commit) begin
      acc_cnt_r  <= acc_cnt_r + 64'd1;
      miss_cnt_r <= miss_cnt_r + (hit ? 64'd0 : 64'd1);
    end
  end

  assign sel_way32 = 32'(sel_way);

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit          <= hit;
      out_way          <= sel_way32[salc_pkg::WAY_OUT_W-1:0];
      out_access_count <= acc_cnt_r + 64'd1;
      out_miss_count   <= miss_cnt_r + (hit ? 64'd0 : 64'd1);
    end
  end

endmodule

FILE: design/set_assoc_lru_cache_tags.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags - set-associative cache tag lookup with true LRU
// Top level: configuration registers, sequencer and datapath.
// ----------------------------------------------------------------------------
// Each accepted address is split into offset, set index and tag, looked up in
// its set, and answered with hit, way and running access/miss counts; a miss
// refills the least recently used way. After reset the block sweeps its set
// memory once, one set per cycle (MAX_SETS sets, 1024 by default), with
// in_ready low; configuration writes are taken throughout. An access then
// passes through capture, set read and write-back; the next transfer is
// captured in the write-back step, so the block takes a new access while it
// writes the last one back, the sequencer alternating set reads and write-backs.
// A result waiting on out_ready holds the next access in write-back.
module set_assoc_lru_cache_tags #(
  parameter int MAX_WAYS   = salc_pkg::MAX_WAYS_DEF,
  parameter int MAX_SETS   = salc_pkg::MAX_SETS_DEF,
  parameter int ADDR_WIDTH = salc_pkg::ADDR_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [salc_pkg::PADDR_W-1:0]     paddr,
  input  logic [salc_pkg::PDATA_W-1:0]     pwdata,
  output logic [salc_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [ADDR_WIDTH-1:0]            in_address,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_hit,
  output logic [salc_pkg::WAY_OUT_W-1:0]   out_way,
  output logic [salc_pkg::CNT_W-1:0]       out_access_count,
  output logic [salc_pkg::CNT_W-1:0]       out_miss_count
);

  salc_pkg::cfg_t    cfg_r;
  salc_pkg::dp_cmd_t cmd;
  salc_pkg::dp_sts_t sts;
  logic              cfg_we;
  logic [1:0]        reg_sel;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.offset_bits <= salc_pkg::OFFSET_RST;
      cfg_r.index_bits  <= salc_pkg::INDEX_RST;
      cfg_r.ways_in_use <= salc_pkg::WAYS_RST;
    end else if (cfg_we) begin
      case (reg_sel)
        salc_pkg::REG_OFFSET_BITS: cfg_r.offset_bits <= pwdata[salc_pkg::OFFSET_W-1:0];
        salc_pkg::REG_INDEX_BITS:  cfg_r.index_bits  <= pwdata[salc_pkg::INDEX_W-1:0];
        salc_pkg::REG_WAYS_IN_USE: cfg_r.ways_in_use <= pwdata[salc_pkg::WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      salc_pkg::REG_OFFSET_BITS: prdata = salc_pkg::PDATA_W'(cfg_r.offset_bits);
      salc_pkg::REG_INDEX_BITS:  prdata = salc_pkg::PDATA_W'(cfg_r.index_bits);
      salc_pkg::REG_WAYS_IN_USE: prdata = salc_pkg::PDATA_W'(cfg_r.ways_in_use);
      default:                   prdata = '0;
    endcase
  end

  salc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  salc_dpath #(
    .MAX_WAYS   (MAX_WAYS),
    .MAX_SETS   (MAX_SETS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .cmd              (cmd),
    .sts              (sts),
    .in_address       (in_address),
    .out_hit          (out_hit),
    .out_way          (out_way),
    .out_access_count (out_access_count),
    .out_miss_count   (out_miss_count)
  );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - regression bench for the set-associative LRU cache tag block
// Streams byte addresses through the block under several cache geometries
// and compares every result with a cycle-free model of the tag array and its
// true-LRU ranks. Both handshake sides idle at random, and one long receiver
// hold-off backs the block up until its input stalls.
// ----------------------------------------------------------------------------
module tb;

  localparam int NUM_SETS    = salc_pkg::MAX_SETS_DEF;
  localparam int NUM_WAYS    = salc_pkg::MAX_WAYS_DEF;
  localparam int STALL_LIMIT = 4000;  // covers the post-reset set sweep
  localparam int HOLD_AT     = 60;    // addresses taken before the long hold-off
  localparam int HOLD_LEN    = 300;

  typedef struct packed {
    logic                           hit;
    logic [salc_pkg::WAY_OUT_W-1:0] way;
    logic [salc_pkg::CNT_W-1:0]     accesses;
    logic [salc_pkg::CNT_W-1:0]     misses;
  } lookup_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [salc_pkg::PADDR_W-1:0]   paddr = '0;
  logic [salc_pkg::PDATA_W-1:0]   pwdata = '0;
  logic [salc_pkg::PDATA_W-1:0]   prdata;
  logic                           pready;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [31:0]                    in_address = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic                           out_hit;
  logic [salc_pkg::WAY_OUT_W-1:0] out_way;
  logic [salc_pkg::CNT_W-1:0]     out_access_count;
  logic [salc_pkg::CNT_W-1:0]     out_miss_count;

  // model of the tag array
  logic [31:0]                tag_mem   [NUM_SETS][NUM_WAYS];
  bit                         line_valid[NUM_SETS][NUM_WAYS];
  logic [2:0]                 rank_mem  [NUM_SETS][NUM_WAYS];
  logic [salc_pkg::CNT_W-1:0] n_access;
  logic [salc_pkg::CNT_W-1:0] n_miss;
  logic [4:0]                 cfg_offset = salc_pkg::OFFSET_RST;
  logic [3:0]                 cfg_index  = salc_pkg::INDEX_RST;
  logic [3:0]                 cfg_ways   = salc_pkg::WAYS_RST;

  logic [31:0]    addr_queue[$];
  lookup_result_t awaited_results[$];
  logic [31:0]    hot_lines[64];
  int             hot_count;
  int             send_idle_pct = 0;
  int             recv_idle_pct = 0;
  int             addrs_accepted = 0;
  int             hold_left = 0;
  bit             hold_done = 1'b0;
  int             stall_cycles = 0;
  int             mismatches = 0;

  set_assoc_lru_cache_tags dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_address       (in_address),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_hit          (out_hit),
    .out_way          (out_way),
    .out_access_count (out_access_count),
    .out_miss_count   (out_miss_count)
  );

  always #5 clk = ~clk;

  // Looks one address up, updates tags and LRU ranks, returns the answer.
  function automatic lookup_result_t cache_lookup(input logic [31:0] addr);
    int             ways;
    int             set_idx;
    int             shift;
    int             w;
    int             hit_way;
    int             old_rank;
    logic [63:0]    wide;
    logic [31:0]    tag;
    bit             found;
    lookup_result_t r;
    ways = (cfg_ways == 0) ? 1 : (cfg_ways > NUM_WAYS) ? NUM_WAYS : int'(cfg_ways);
    wide = {32'd0, addr};
    set_idx = int'((wide >> cfg_offset) & ((64'd1 << cfg_index) - 64'd1)) % NUM_SETS;
    shift = int'(cfg_offset) + int'(cfg_index);
    tag = 32'(wide >> shift);
    found = 1'b0;
    hit_way = 0;
    for (w = 0; w < ways; w++) begin
      if (!found && line_valid[set_idx][w] && tag_mem[set_idx][w] == tag) begin
        found = 1'b1;
        hit_way = w;
      end
    end
    n_access = n_access + 1;
    if (!found) begin
      n_miss = n_miss + 1;
      // victim: oldest rank among the ways in use
      for (w = 1; w < ways; w++) begin
        if (rank_mem[set_idx][w] > rank_mem[set_idx][hit_way]) begin
          hit_way = w;
        end
      end
      tag_mem[set_idx][hit_way] = tag;
      line_valid[set_idx][hit_way] = 1'b1;
    end
    // move to front over all ways, in use or not
    old_rank = rank_mem[set_idx][hit_way];
    for (w = 0; w < NUM_WAYS; w++) begin
      if (rank_mem[set_idx][w] < old_rank) begin
        rank_mem[set_idx][w] = rank_mem[set_idx][w] + 1;
      end
    end
    rank_mem[set_idx][hit_way] = 3'd0;
    r.hit = found;
    r.way = hit_way[salc_pkg::WAY_OUT_W-1:0];
    r.accesses = n_access;
    r.misses = n_miss;
    return r;
  endfunction

  // input side: offer addresses, predict on each transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        awaited_results.push_back(cache_lookup(in_address));
        addrs_accepted <= addrs_accepted + 1;
      end
      if (!in_valid || in_ready) begin
        if (addr_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_address <= addr_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side backpressure, with one long hold-off to fill the block
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && addrs_accepted == HOLD_AT) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // result check and watchdog
  always @(posedge clk) begin : result_check
    lookup_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected result hit=%0b way=%0d acc=%0d miss=%0d", $realtime,
                   out_hit, out_way, out_access_count, out_miss_count);
        end
      end else begin
        exp_r = awaited_results.pop_front();
        if (out_hit !== exp_r.hit || out_way !== exp_r.way ||
            out_access_count !== exp_r.accesses || out_miss_count !== exp_r.misses) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: mismatch exp hit=%0b way=%0d acc=%0d miss=%0d", $realtime,
                     exp_r.hit, exp_r.way, exp_r.accesses, exp_r.misses);
            $display("%0t:          got hit=%0b way=%0d acc=%0d miss=%0d", $realtime,
                     out_hit, out_way, out_access_count, out_miss_count);
          end
        end
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
      $display("set_assoc_lru_cache_tags regression: fail");
      $finish;
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [salc_pkg::PDATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      salc_pkg::REG_OFFSET_BITS: cfg_offset = value[4:0];
      salc_pkg::REG_INDEX_BITS:  cfg_index = value[3:0];
      salc_pkg::REG_WAYS_IN_USE: cfg_ways = value[3:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (addr_queue.size() != 0 || in_valid || awaited_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  // Drain, reprogram the geometry, then queue n addresses biased toward a
  // small pool of hot lines so that hits and evictions both show up.
  task automatic run_phase(input int snd_pct, input int rcv_pct, input logic [4:0] off,
                           input logic [3:0] idx, input logic [3:0] ways, input int n);
    logic [31:0] off_mask;
    logic [31:0] a;
    wait_drained();
    reg_write(salc_pkg::REG_OFFSET_BITS, {27'd0, off});
    reg_write(salc_pkg::REG_INDEX_BITS, {28'd0, idx});
    reg_write(salc_pkg::REG_WAYS_IN_USE, {28'd0, ways});
    @(negedge clk);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    hot_count = $urandom_range(4, 40);
    for (int i = 0; i < hot_count; i++) hot_lines[i] = $urandom;
    off_mask = (32'd1 << off) - 32'd1;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) != 0) begin
        a = hot_lines[$urandom_range(0, hot_count - 1)] ^ ($urandom & off_mask);
      end else begin
        a = $urandom;
      end
      addr_queue.push_back(a);
    end
  endtask

  initial begin
    for (int s = 0; s < NUM_SETS; s++) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        tag_mem[s][w] = '0;
        line_valid[s][w] = 1'b0;
        rank_mem[s][w] = w[2:0];
      end
    end
    n_access = '0;
    n_miss = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: 4 sets of 32-byte lines, 4 ways; set 0 filled then evicted
    run_phase(34, 56, 5'd5, 4'd2, 4'd4, 0);
    @(negedge clk);
    addr_queue = '{32'h0000_0000, 32'h0000_001F, 32'hFFFF_FFFF, 32'hFFFF_FFE0,
                   32'h0000_0080, 32'h0000_0100, 32'h0000_0180, 32'h0000_0200,
                   32'h0000_0080, 32'h0000_0280, 32'h0000_0000, 32'h0000_0100,
                   32'h8000_0000, 32'h8000_0040, 32'h7FFF_FFFF, 32'h0000_0020,
                   32'h0000_0040, 32'h0000_0060, 32'h0000_0180, 32'h0000_0200};

    run_phase(34, 56, 5'd4, 4'd3, 4'd4, 120);
    run_phase(34, 56, 5'd0, 4'd0, 4'd1, 50);
    // split wider than the address, ways clamp to 8
    run_phase(56, 34, 5'd31, 4'd15, 4'd15, 50);
    // set index wider than the set memory wraps
    run_phase(56, 34, 5'd2, 4'd13, 4'd8, 70);
    // zero ways behaves as one
    run_phase(56, 34, 5'd3, 4'd2, 4'd0, 50);
    run_phase(0, 0, 5'd6, 4'd4, 4'd2, 60);
    run_phase(0, 0, 5'd5, 4'd1, 4'd6, 60);

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("set_assoc_lru_cache_tags regression: pass");
    end else begin
      $display("set_assoc_lru_cache_tags regression: fail");
    end
    $finish;
  end

endmodule
